FILE: hw/rtl/pfat_pkg.sv
// Shared types and constants for the PWM feedback angle tracker.
package pfat_pkg;

    // Field widths
    localparam int TIME_W   = 13;
    localparam int PERIOD_W = 14;
    localparam int ANGLE_W  = 12;
    localparam int TURNS_W  = 16;
    localparam int TOTAL_W  = 28;
    localparam int UNITS_W  = 13;
    localparam int DUTY_W   = 12;
    localparam int CYCLE_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Shared divider: dividend width, divisor width, two quotient bits per cycle
    localparam int DIV_W    = 26;
    localparam int DEN_W    = 14;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W / 2 - 1);

    // Product and sum widths
    localparam int ANG_PROD_W = 27;
    localparam int TOT_PROD_W = 30;
    localparam int ANG_RAW_W  = 28;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Q2_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Q3_MAX      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MAX   = 3'd7;

    // Register reset values
    localparam logic [DUTY_W-1:0]  RST_DUTY_SCALE = 12'd1000;
    localparam logic [UNITS_W-1:0] RST_UNITS      = 13'd360;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MIN   = 12'd29;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MAX   = 12'd971;
    localparam logic [ANGLE_W-1:0] RST_Q2_MIN     = 12'd90;
    localparam logic [ANGLE_W-1:0] RST_Q3_MAX     = 12'd270;
    localparam logic [CYCLE_W-1:0] RST_CYCLE_MIN  = 14'd1000;
    localparam logic [CYCLE_W-1:0] RST_CYCLE_MAX  = 14'd1200;

    // Saturation limits
    localparam logic signed [TURNS_W-1:0] TURNS_MAX = 16'sh7FFF;
    localparam logic signed [TURNS_W-1:0] TURNS_MIN = 16'sh8000;
    localparam logic signed [TOT_PROD_W-1:0] TOTAL_MAX = 30'sd134217727;
    localparam logic signed [TOT_PROD_W-1:0] TOTAL_MIN = -30'sd134217728;
    localparam logic [ANGLE_W-1:0] ANGLE_TOP_MAX = 12'd4095;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_ANGLE,
        ST_ANGLE,
        ST_TURNS,
        ST_MUL_TOTAL,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/pwm_feedback_angle_tracker_core.sv
// PWM feedback angle tracker: period check, duty and angle division, turn counting.
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+-----------------------------------------
//  input    | s_tvalid s_tready s_tdata     | one high/low time pair per transfer
//  result   | m_tvalid m_tready m_tdata     | one result per input transfer
//           | m_tuser                       |   m_tuser = sample_valid
//  config   | cfg_valid cfg_ready cfg_index | register write, always ready
//           | cfg_data                      |
//
// Sequence: a valid item passes ST_CHECK, the duty division, ST_MUL_ANGLE, the angle
// division, ST_ANGLE, ST_TURNS, ST_MUL_TOTAL and ST_SUM; its result is loaded in ST_DONE.
// The shared restoring divider, two quotient bits a cycle, serves duty and then angle.
// An out-of-bounds item goes from ST_CHECK straight to ST_DONE, where its result is loaded.
// Reset: synchronous, active low; registers go to their documented defaults,
// turn state clears. One item in flight; s_tready is high only when idle.
// A finished result waits in the output register, and the next item may be
// taken while it waits; the sequencer holds in its last step until it is free.
module pwm_feedback_angle_tracker_core
    import pfat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [12:0] high_time, [25:13] low_time, [31:26] zero
    input  logic [31:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] single_turn_angle, [27:12] turn_count, [55:28] total_angle
    output logic [55:0]           m_tdata,
    // [0] sample_valid
    output logic                  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration ----------------
    logic [DUTY_W-1:0]  duty_scale_reg;
    logic [UNITS_W-1:0] units_reg;
    logic [DUTY_W-1:0]  duty_min_reg;
    logic [DUTY_W-1:0]  duty_max_reg;
    logic [ANGLE_W-1:0] q2_min_reg;
    logic [ANGLE_W-1:0] q3_max_reg;
    logic [CYCLE_W-1:0] cycle_min_reg;
    logic [CYCLE_W-1:0] cycle_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_scale_reg <= RST_DUTY_SCALE;
            units_reg      <= RST_UNITS;
            duty_min_reg   <= RST_DUTY_MIN;
            duty_max_reg   <= RST_DUTY_MAX;
            q2_min_reg     <= RST_Q2_MIN;
            q3_max_reg     <= RST_Q3_MAX;
            cycle_min_reg  <= RST_CYCLE_MIN;
            cycle_max_reg  <= RST_CYCLE_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DUTY_SCALE: duty_scale_reg <= cfg_data[DUTY_W-1:0];
                CFG_UNITS:      units_reg      <= cfg_data[UNITS_W-1:0];
                CFG_DUTY_MIN:   duty_min_reg   <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MAX:   duty_max_reg   <= cfg_data[DUTY_W-1:0];
                CFG_Q2_MIN:     q2_min_reg     <= cfg_data[ANGLE_W-1:0];
                CFG_Q3_MAX:     q3_max_reg     <= cfg_data[ANGLE_W-1:0];
                CFG_CYCLE_MIN:  cycle_min_reg  <= cfg_data[CYCLE_W-1:0];
                CFG_CYCLE_MAX:  cycle_max_reg  <= cfg_data[CYCLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    state_t state_reg, state_next;

    logic [TIME_W-1:0]     high_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [DIV_W-1:0]      quo_reg;      // dividend shifts out the top, quotient in at the bottom
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  div_sel_reg;  // 0: duty division, 1: angle division
    logic                  neg_reg;      // angle quotient sign
    logic [ANGLE_W-1:0]    theta_reg;
    logic signed [TOT_PROD_W-1:0] prod_reg;
    logic                  ok_reg;

    logic [ANGLE_W-1:0]         prev_reg;
    logic signed [TURNS_W-1:0]  turns_reg;
    logic                       primed_reg;
    logic signed [TOTAL_W-1:0]  last_total_reg;

    logic                       m_tvalid_reg;
    logic                       m_valid_reg;
    logic [ANGLE_W-1:0]         m_angle_reg;
    logic signed [TURNS_W-1:0]  m_turns_reg;
    logic signed [TOTAL_W-1:0]  m_total_reg;

    logic in_xfer;
    logic out_free;
    logic out_load;
    logic item_ok;
    logic div_done;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign div_done = (cnt_reg == '0);

    // period bounds and a nonzero angle divisor
    logic [DUTY_W:0] duty_max_p1;
    assign duty_max_p1 = {1'b0, duty_max_reg} + 13'd1;
    assign item_ok = (period_reg != '0) && (period_reg >= cycle_min_reg) &&
                     (period_reg <= cycle_max_reg) &&
                     (duty_max_p1 != {1'b0, duty_min_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_xfer) state_next = ST_CHECK;
            ST_CHECK:     state_next = item_ok ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (div_done) state_next = div_sel_reg ? ST_ANGLE : ST_MUL_ANGLE;
            end
            ST_MUL_ANGLE: state_next = ST_DIV;
            ST_ANGLE:     state_next = ST_TURNS;
            ST_TURNS:     state_next = ST_MUL_TOTAL;
            ST_MUL_TOTAL: state_next = ST_SUM;
            ST_SUM:       state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // ---------------- shared divider step (two bits) ----------------
    logic [DEN_W:0]   t1, t2;
    logic             ge1, ge2;
    logic [DEN_W-1:0] r1, r2;

    always_comb begin
        t1  = {rem_reg, quo_reg[DIV_W-1]};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? DEN_W'(t1 - {1'b0, den_reg}) : t1[DEN_W-1:0];
        t2  = {r1, quo_reg[DIV_W-2]};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? DEN_W'(t2 - {1'b0, den_reg}) : t2[DEN_W-1:0];
    end

    // ---------------- arithmetic per step ----------------
    // (duty - duty_min) * units over the signed angle divisor
    logic signed [DUTY_W:0]      duty_diff;
    logic signed [UNITS_W:0]     units_s;
    logic signed [ANG_PROD_W-1:0] ang_prod;
    logic [DIV_W-1:0]            ang_mag;
    logic signed [DEN_W-1:0]     ang_div;
    logic [DEN_W-1:0]            ang_div_mag;

    assign duty_diff   = $signed({1'b0, quo_reg[DUTY_W-1:0]}) - $signed({1'b0, duty_min_reg});
    assign units_s     = $signed({1'b0, units_reg});
    assign ang_prod    = duty_diff * units_s;
    assign ang_mag     = ang_prod[ANG_PROD_W-1] ? DIV_W'(-ang_prod) : ang_prod[DIV_W-1:0];
    assign ang_div     = $signed({2'b00, duty_max_reg}) - $signed({2'b00, duty_min_reg})
                         + 14'sd1;
    assign ang_div_mag = ang_div[DEN_W-1] ? DEN_W'(-ang_div) : ang_div;

    // angle = (units - 1) - quotient, clamped to one turn
    logic signed [ANG_RAW_W-1:0] q_s;
    logic signed [ANG_RAW_W-1:0] angle_raw;
    logic [ANGLE_W-1:0]          angle_top;
    logic [ANGLE_W-1:0]          angle_clamped;

    always_comb begin
        q_s       = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        angle_raw = $signed({15'd0, units_reg}) - 28'sd1 - q_s;
        if (units_reg == '0)
            angle_top = '0;
        else if (units_reg > {1'b0, ANGLE_TOP_MAX})
            angle_top = ANGLE_TOP_MAX;
        else
            angle_top = ANGLE_W'(units_reg - 13'd1);
        if (angle_raw < 0)
            angle_clamped = '0;
        else if (angle_raw > $signed({16'd0, angle_top}))
            angle_clamped = angle_top;
        else
            angle_clamped = angle_raw[ANGLE_W-1:0];
    end

    // turns * units + theta, saturated to the total range
    logic signed [TOT_PROD_W-1:0] total_sum;
    logic signed [TOTAL_W-1:0]    total_sat;

    always_comb begin
        total_sum = prod_reg + $signed({18'd0, theta_reg});
        if (total_sum > TOTAL_MAX)      total_sat = TOTAL_MAX[TOTAL_W-1:0];
        else if (total_sum < TOTAL_MIN) total_sat = TOTAL_MIN[TOTAL_W-1:0];
        else                            total_sat = total_sum[TOTAL_W-1:0];
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    high_reg   <= s_tdata[TIME_W-1:0];
                    period_reg <= {1'b0, s_tdata[TIME_W-1:0]} +
                                  {1'b0, s_tdata[2*TIME_W-1:TIME_W]};
                end
            end
            ST_CHECK: begin
                ok_reg      <= item_ok;
                quo_reg     <= {14'd0, duty_scale_reg} * {13'd0, high_reg};
                den_reg     <= period_reg;
                rem_reg     <= '0;
                cnt_reg     <= DIV_LAST;
                div_sel_reg <= 1'b0;
            end
            ST_DIV: begin
                quo_reg <= {quo_reg[DIV_W-3:0], ge1, ge2};
                rem_reg <= r2;
                cnt_reg <= cnt_reg - 4'd1;
            end
            ST_MUL_ANGLE: begin
                quo_reg     <= ang_mag;
                den_reg     <= ang_div_mag;
                neg_reg     <= ang_prod[ANG_PROD_W-1] ^ ang_div[DEN_W-1];
                rem_reg     <= '0;
                cnt_reg     <= DIV_LAST;
                div_sel_reg <= 1'b1;
            end
            ST_ANGLE:     theta_reg <= angle_clamped;
            ST_MUL_TOTAL: prod_reg  <= turns_reg * units_s;
            default: ;
        endcase
    end

    // tracked turn state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            turns_reg      <= '0;
            primed_reg     <= 1'b0;
            last_total_reg <= '0;
        end else begin
            if (state_reg == ST_TURNS) begin
                if (primed_reg) begin
                    // quadrant 4 to quadrant 1 is a forward wrap, the reverse a backward one
                    if (theta_reg < q2_min_reg && prev_reg > q3_max_reg) begin
                        if (turns_reg != TURNS_MAX) turns_reg <= turns_reg + 16'sd1;
                    end else if (prev_reg < q2_min_reg && theta_reg > q3_max_reg) begin
                        if (turns_reg != TURNS_MIN) turns_reg <= turns_reg - 16'sd1;
                    end
                end
                primed_reg <= 1'b1;
                prev_reg   <= theta_reg;
            end
            if (state_reg == ST_SUM) last_total_reg <= total_sat;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_valid_reg <= ok_reg;
            m_angle_reg <= prev_reg;
            m_turns_reg <= turns_reg;
            m_total_reg <= last_total_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_turns_reg, m_angle_reg};

endmodule
